// ----- hdl/pprq_pkg.sv -----
// Package for the pinned priority run queue: sizes, command/status codes, FSM states.
// No dependencies.
package pprq_pkg;
	localparam int LEVELS_DEF  = 64;
	localparam int THREADS_DEF = 64;
	localparam int CPUS_DEF    = 8;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_PRE  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_QUEUED = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_HREAD,
		S_WALK,
		S_WAIT,
		S_UNLINK,
		S_UNLINK2,
		S_UNLINK3,
		S_AREAD,
		S_AWAIT,
		S_APPEND,
		S_DONE
	} state_t;
endpackage

// ----- hdl/pprq_if.sv -----
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface pprq_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/pprq_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pprq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/pinned_priority_run_queue.sv -----
// Pinned priority run queue top level. Uses pprq_pkg, pprq_if, pprq_ram.
// Flow: an enqueue reads the level record, writes it and the new node and, when the level
//   already holds threads, links the old tail; a rejected enqueue or unused command goes
//   straight to the result. Dequeue scans the levels up to its limit, walks each nonempty
//   level from its head, unlinks the first eligible entry and reports; preempt then appends.
// One item in flight: the next item is accepted from the edge after the result
//   is taken. Reset: arst_n clears the nonempty and queued bitmaps and the control state.
module pinned_priority_run_queue #(
	parameter int LEVELS  = pprq_pkg::LEVELS_DEF,
	parameter int THREADS = pprq_pkg::THREADS_DEF
) (
	input logic clk,
	input logic arst_n,
	pprq_if.sink   in_ch,
	pprq_if.source out_ch
);
	localparam int LW = $clog2(LEVELS);
	localparam int TW = $clog2(THREADS);
	localparam int NW = TW + 1; // link with "none" flag in msb
	localparam logic [NW-1:0] NIL = {1'b1, {TW{1'b0}}};

	// node memory: {pin, prev, next}
	localparam int NODEW = 4 + 2 * NW;

	pprq_pkg::state_t state_q, state_d;

	logic [1:0]    cmd_q;
	logic [5:0]    tid_q;
	logic [3:0]    pin_q;
	logic [2:0]    cpu_q;
	logic [LW-1:0] lim_q, lvl_q, alvl_q;
	logic [NW-1:0] cur_q, tkp_q, tkn_q;
	logic [TW-1:0] tk_q, atl_q;
	pprq_pkg::status_t status_q;
	logic          found_q;
	logic [5:0]    next_q;
	logic          ovalid_q;
	logic          took_q;
	logic          cur_queued_app_q;

	logic [LEVELS-1:0]  nonempty_q;
	logic [THREADS-1:0] queued_q;

	// level memory: {tail, head}; node memory
	logic          lm_we, nm_we;
	logic [LW-1:0] lm_wa, lm_ra;
	logic [2*TW-1:0] lm_wd, lm_rd;
	logic [TW-1:0] nm_wa, nm_ra;
	logic [NODEW-1:0] nm_wd, nm_rd;

	pprq_ram #(.WIDTH(2*TW), .DEPTH(LEVELS)) u_lvl (
		.clk(clk), .we(lm_we), .waddr(lm_wa), .wdata(lm_wd), .raddr(lm_ra), .rdata(lm_rd)
	);
	pprq_ram #(.WIDTH(NODEW), .DEPTH(THREADS)) u_node (
		.clk(clk), .we(nm_we), .waddr(nm_wa), .wdata(nm_wd), .raddr(nm_ra), .rdata(nm_rd)
	);

	logic [3:0]    rd_pin;
	logic [NW-1:0] rd_prev, rd_next;
	logic [TW-1:0] rd_head, rd_tail;
	assign rd_pin  = nm_rd[NODEW-1 -: 4];
	assign rd_prev = nm_rd[2*NW-1 -: NW];
	assign rd_next = nm_rd[NW-1:0];
	assign rd_head = lm_rd[TW-1:0];
	assign rd_tail = lm_rd[2*TW-1 -: TW];

	logic elig;
	assign elig = rd_pin[3] || (rd_pin == {1'b0, cpu_q});

	logic in_fire, out_fire;
	assign in_ch.ready = (state_q == pprq_pkg::S_IDLE) && !ovalid_q;
	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data.status      = status_q;
	assign out_ch.data.found       = found_q;
	assign out_ch.data.next_thread = next_q;

	// incoming fields with saturation
	logic [LW-1:0] in_prio_sat, in_max_sat;
	logic          in_tid_ok, tid_ok_q;
	always_comb begin
		in_prio_sat = (32'(in_ch.data.priority_req) >= LEVELS) ? LW'(LEVELS - 1)
			: LW'(in_ch.data.priority_req);
		in_max_sat = (32'(in_ch.data.max_priority) >= LEVELS) ? LW'(LEVELS - 1)
			: LW'(in_ch.data.max_priority);
		in_tid_ok = 32'(in_ch.data.thread_id) < THREADS;
	end

	logic [TW-1:0] tid_t;
	assign tid_t = TW'(tid_q);

	// next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			pprq_pkg::S_IDLE: begin
				if (in_fire) begin
					case (in_ch.data.command)
						pprq_pkg::CMD_ENQ: state_d = (!in_tid_ok ||
							queued_q[TW'(in_ch.data.thread_id)]) ? pprq_pkg::S_DONE
							: pprq_pkg::S_AREAD;
						pprq_pkg::CMD_DEQ, pprq_pkg::CMD_PRE: state_d = pprq_pkg::S_SCAN;
						default: state_d = pprq_pkg::S_DONE;
					endcase
				end
			end
			pprq_pkg::S_SCAN: begin
				if (nonempty_q[lvl_q]) state_d = pprq_pkg::S_HREAD;
				else if (lvl_q == lim_q) state_d = pprq_pkg::S_DONE;
			end
			pprq_pkg::S_HREAD: state_d = pprq_pkg::S_WALK;
			pprq_pkg::S_WALK: begin
				if (cur_q[NW-1]) state_d = (lvl_q == lim_q) ? pprq_pkg::S_DONE
					: pprq_pkg::S_SCAN;
				else state_d = pprq_pkg::S_WAIT;
			end
			pprq_pkg::S_WAIT: begin
				state_d = elig ? pprq_pkg::S_UNLINK : pprq_pkg::S_WALK;
			end
			pprq_pkg::S_UNLINK: state_d = pprq_pkg::S_UNLINK2;
			pprq_pkg::S_UNLINK2: state_d = pprq_pkg::S_UNLINK3;
			pprq_pkg::S_UNLINK3: state_d = (cmd_q == pprq_pkg::CMD_PRE && tid_ok_q &&
				!queued_q[tid_t]) ? pprq_pkg::S_AREAD : pprq_pkg::S_DONE;
			pprq_pkg::S_AREAD: state_d = pprq_pkg::S_AWAIT;
			pprq_pkg::S_AWAIT: state_d = nonempty_q[alvl_q] ? pprq_pkg::S_APPEND
				: pprq_pkg::S_DONE;
			pprq_pkg::S_APPEND: state_d = pprq_pkg::S_DONE;
			pprq_pkg::S_DONE: state_d = pprq_pkg::S_IDLE;
			default: state_d = pprq_pkg::S_IDLE;
		endcase
	end

	// memory port control; every write lands before the next read of that entry
	always_comb begin
		lm_we = 1'b0; lm_wa = lvl_q; lm_wd = lm_rd; lm_ra = lvl_q;
		nm_we = 1'b0; nm_wa = tkp_q[TW-1:0]; nm_wd = nm_rd; nm_ra = cur_q[TW-1:0];
		case (state_q)
			pprq_pkg::S_UNLINK: begin
				// fix the level record: head/tail; read the prev node
				lm_we = tkp_q[NW-1] || tkn_q[NW-1];
				lm_wd = {(tkn_q[NW-1] ? tkp_q[TW-1:0] : rd_tail),
					(tkp_q[NW-1] ? tkn_q[TW-1:0] : rd_head)};
				nm_ra = tkp_q[TW-1:0];
			end
			pprq_pkg::S_UNLINK2: begin
				// point prev at next; read the next node
				nm_we = !tkp_q[NW-1]; nm_wa = tkp_q[TW-1:0];
				nm_wd = {rd_pin, rd_prev, tkn_q};
				nm_ra = tkn_q[TW-1:0];
			end
			pprq_pkg::S_UNLINK3: begin
				// point next back at prev
				nm_we = !tkn_q[NW-1]; nm_wa = tkn_q[TW-1:0];
				nm_wd = {rd_pin, tkp_q, rd_next};
			end
			pprq_pkg::S_AREAD: lm_ra = alvl_q;
			pprq_pkg::S_AWAIT: begin
				// write the level record and the new node; read the old tail node
				lm_ra = alvl_q;
				lm_we = 1'b1; lm_wa = alvl_q;
				lm_wd = nonempty_q[alvl_q] ? {tid_t, rd_head} : {tid_t, tid_t};
				nm_we = 1'b1; nm_wa = tid_t;
				nm_wd = {pin_q, (nonempty_q[alvl_q] ? {1'b0, rd_tail} : NIL), NIL};
				nm_ra = rd_tail;
			end
			pprq_pkg::S_APPEND: begin
				// link the old tail to the new thread
				nm_we = 1'b1; nm_wa = atl_q;
				nm_wd = {rd_pin, rd_prev, {1'b0, tid_t}};
			end
			default: ;
		endcase
	end

	// control state and bitmaps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pprq_pkg::S_IDLE;
			ovalid_q   <= 1'b0;
			nonempty_q <= '0;
			queued_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pprq_pkg::S_DONE) ovalid_q <= 1'b1;
			else if (out_fire) ovalid_q <= 1'b0;
			case (state_q)
				pprq_pkg::S_UNLINK: begin
					if (tkp_q[NW-1] && tkn_q[NW-1]) nonempty_q[lvl_q] <= 1'b0;
					queued_q[tk_q] <= 1'b0;
				end
				pprq_pkg::S_AWAIT: begin
					nonempty_q[alvl_q] <= 1'b1;
					queued_q[tid_t]    <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pprq_pkg::S_IDLE: begin
				cmd_q  <= in_ch.data.command;
				tid_q  <= in_ch.data.thread_id;
				tid_ok_q <= in_tid_ok;
				pin_q  <= in_ch.data.pin;
				cpu_q  <= in_ch.data.cpu_id;
				alvl_q <= in_prio_sat;
				lim_q  <= (in_ch.data.command == pprq_pkg::CMD_PRE) ? in_prio_sat : in_max_sat;
				lvl_q  <= '0;
				took_q <= 1'b0;
			end
			pprq_pkg::S_SCAN: if (!nonempty_q[lvl_q] && lvl_q != lim_q) lvl_q <= lvl_q + LW'(1);
			pprq_pkg::S_HREAD: cur_q <= {1'b0, rd_head};
			pprq_pkg::S_WALK: if (cur_q[NW-1] && lvl_q != lim_q) lvl_q <= lvl_q + LW'(1);
			pprq_pkg::S_WAIT: begin
				if (elig) begin
					tk_q  <= cur_q[TW-1:0];
					tkp_q <= rd_prev;
					tkn_q <= rd_next;
					took_q <= 1'b1;
				end else begin
					cur_q <= rd_next;
				end
			end
			pprq_pkg::S_AWAIT: atl_q <= rd_tail;
			pprq_pkg::S_DONE: begin
				case (cmd_q)
					pprq_pkg::CMD_ENQ: begin
						status_q <= cur_queued_app_q ? pprq_pkg::ST_OK : pprq_pkg::ST_QUEUED;
						found_q <= 1'b0; next_q <= '0;
					end
					pprq_pkg::CMD_DEQ: begin
						status_q <= took_q ? pprq_pkg::ST_OK : pprq_pkg::ST_EMPTY;
						found_q <= took_q;
						next_q <= took_q ? 6'(tk_q) : '0;
					end
					pprq_pkg::CMD_PRE: begin
						status_q <= pprq_pkg::ST_OK;
						found_q <= 1'b1;
						next_q <= took_q ? 6'(tk_q) : tid_q;
					end
					default: begin
						status_q <= pprq_pkg::ST_OK; found_q <= 1'b0; next_q <= '0;
					end
				endcase
			end
			default: ;
		endcase
	end

	// enqueue status: remember the append happened
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cur_queued_app_q <= 1'b0;
		else if (state_q == pprq_pkg::S_IDLE) cur_queued_app_q <= 1'b0;
		else if (state_q == pprq_pkg::S_AWAIT) cur_queued_app_q <= 1'b1;
	end

`ifndef NO_ASSERTIONS
	// only one item in flight: no accept while a result waits
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !in_ch.ready) else $error("accept while result pending");
	// a result that reports found never reports empty
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && found_q) |-> (status_q == pprq_pkg::ST_OK))
		else $error("found with bad status");
	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(next_q)
		&& $stable(found_q) && $stable(status_q)))
		else $error("result changed while waiting");
`endif
endmodule

// ----- sim/pprq_tb_pkg.sv -----
// Item layouts for the run queue channels, shared by the checker and the test top.
// Depends on pprq_pkg.
`timescale 1ns / 1ps
package pprq_tb_pkg;
	typedef struct packed {
		pprq_pkg::cmd_t    command;
		logic [5:0]        thread_id;
		logic [5:0]        priority_req;
		logic signed [3:0] pin;
		logic [2:0]        cpu_id;
		logic [5:0]        max_priority;
	} sched_req_t;

	typedef struct packed {
		pprq_pkg::status_t status;
		logic              found;
		logic [5:0]        next_thread;
	} sched_resp_t;
endpackage

// ----- sim/pprq_checker.sv -----
// Scoreboard for the run queue: mirrors the level lists, predicts each response
// and compares it with the block's output. Depends on pprq_pkg, pprq_tb_pkg, pprq_if.
`timescale 1ns / 1ps
module pprq_checker (
	input  logic clk,
	input  logic arst_n,
	pprq_if      req_ch,
	pprq_if      resp_ch,
	output int   mismatches,
	output int   outstanding
);
	localparam int NLVL = 64;
	localparam int NTHR = 64;
	localparam logic [6:0] NIL = 7'h40;

	logic       lvl_busy [NLVL];
	logic [6:0] lvl_first [NLVL];
	logic [6:0] lvl_last [NLVL];
	logic [6:0] link_fwd [NTHR];
	logic [6:0] link_back [NTHR];
	logic [3:0] thr_pin [NTHR];
	logic       thr_waiting [NTHR];

	pprq_tb_pkg::sched_resp_t pending_resp[$];

	// Append a thread to the tail of its level.
	function automatic void link_tail(logic [5:0] t, logic [5:0] lvl, logic [3:0] p);
		thr_pin[t] = p;
		if (lvl_busy[lvl]) begin
			link_back[t] = lvl_last[lvl];
			link_fwd[lvl_last[lvl][5:0]] = {1'b0, t};
		end else begin
			link_back[t] = NIL;
			lvl_first[lvl] = {1'b0, t};
		end
		link_fwd[t] = NIL;
		lvl_last[lvl] = {1'b0, t};
		lvl_busy[lvl] = 1'b1;
		thr_waiting[t] = 1'b1;
	endfunction

	// Remove the first thread eligible for cpu from levels 0..limit; NIL if none.
	function automatic logic [6:0] pick_thread(logic [5:0] limit, logic [2:0] cpu);
		logic [6:0] t;
		logic [6:0] pv;
		logic [6:0] nx;
		int guard;
		for (int i = 0; i <= int'(limit); i++) begin
			if (!lvl_busy[i]) continue;
			t = lvl_first[i];
			guard = 0;
			while (t < NIL && guard < NTHR) begin
				if (thr_pin[t[5:0]][3] || thr_pin[t[5:0]] == {1'b0, cpu}) break;
				t = link_fwd[t[5:0]];
				guard++;
			end
			if (t >= NIL || guard >= NTHR) continue;
			pv = link_back[t[5:0]];
			nx = link_fwd[t[5:0]];
			if (pv < NIL) link_fwd[pv[5:0]] = nx;
			else lvl_first[i] = nx;
			if (nx < NIL) link_back[nx[5:0]] = pv;
			else lvl_last[i] = pv;
			if (lvl_first[i] >= NIL) lvl_busy[i] = 1'b0;
			thr_waiting[t[5:0]] = 1'b0;
			return t;
		end
		return NIL;
	endfunction

	function automatic pprq_tb_pkg::sched_resp_t schedule(pprq_tb_pkg::sched_req_t r);
		pprq_tb_pkg::sched_resp_t o;
		logic [6:0] t;
		o = '{status: pprq_pkg::ST_OK, found: 1'b0, next_thread: 6'd0};
		case (r.command)
			pprq_pkg::CMD_ENQ: begin
				if (thr_waiting[r.thread_id]) o.status = pprq_pkg::ST_QUEUED;
				else link_tail(r.thread_id, r.priority_req, r.pin);
			end
			pprq_pkg::CMD_DEQ: begin
				t = pick_thread(r.max_priority, r.cpu_id);
				if (t < NIL) begin
					o.found = 1'b1;
					o.next_thread = t[5:0];
				end else begin
					o.status = pprq_pkg::ST_EMPTY;
				end
			end
			pprq_pkg::CMD_PRE: begin
				t = pick_thread(r.priority_req, r.cpu_id);
				o.found = 1'b1;
				if (t < NIL) begin
					if (!thr_waiting[r.thread_id])
						link_tail(r.thread_id, r.priority_req, r.pin);
					o.next_thread = t[5:0];
				end else begin
					o.next_thread = r.thread_id;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// Predict on accepted requests, compare on accepted responses.
	always @(posedge clk or negedge arst_n) begin
		pprq_tb_pkg::sched_resp_t want;
		pprq_tb_pkg::sched_resp_t got;
		if (!arst_n) begin
			for (int i = 0; i < NLVL; i++) lvl_busy[i] = 1'b0;
			for (int i = 0; i < NTHR; i++) thr_waiting[i] = 1'b0;
			pending_resp.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (resp_ch.valid && resp_ch.ready) begin
				got = resp_ch.data;
				if (pending_resp.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected response %p", $realtime, got);
					mismatches++;
				end else begin
					want = pending_resp.pop_front();
					if (got.status !== want.status || got.found !== want.found
						|| got.next_thread !== want.next_thread) begin
						if (mismatches < 10)
							$display("%0t: response mismatch, expected %p, got %p",
								$realtime, want, got);
						mismatches++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready)
				pending_resp.push_back(schedule(req_ch.data));
			outstanding = pending_resp.size();
		end
	end
endmodule

// ----- sim/pinned_priority_run_queue_test.sv -----
// Test top for the run queue: clock, reset, request stimulus and response stalls.
// Depends on pprq_pkg, pprq_tb_pkg, pprq_if, pprq_checker and the block itself.
`timescale 1ns / 1ps
module pinned_priority_run_queue_test;
	localparam int RUN_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   outstanding;
	int   idle_pct = 0;
	int   stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	longint cycles = 0;

	pprq_if #(.payload_t(pprq_tb_pkg::sched_req_t))  req_ch ();
	pprq_if #(.payload_t(pprq_tb_pkg::sched_resp_t)) resp_ch ();

	pinned_priority_run_queue dut (
		.clk(clk), .arst_n(arst_n), .in_ch(req_ch.sink), .out_ch(resp_ch.source)
	);

	pprq_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .req_ch(req_ch), .resp_ch(resp_ch),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Drive response ready: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			resp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			resp_ch.ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= 400;
			hold_done <= 1'b1;
			resp_ch.ready <= 1'b0;
		end else begin
			resp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Idle the sender cycle by cycle, then offer the item until it is taken.
	task automatic send(pprq_tb_pkg::sched_req_t it);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic send_fields(pprq_pkg::cmd_t c, int tid, int prio, int p, int cpu,
		int maxp);
		pprq_tb_pkg::sched_req_t it;
		it.command = c;
		it.thread_id = tid[5:0];
		it.priority_req = prio[5:0];
		it.pin = p[3:0];
		it.cpu_id = cpu[2:0];
		it.max_priority = maxp[5:0];
		send(it);
	endtask

	function automatic pprq_tb_pkg::sched_req_t random_request();
		pprq_tb_pkg::sched_req_t it;
		int r;
		r = $urandom_range(99);
		it.command = r < 45 ? pprq_pkg::CMD_ENQ : r < 75 ? pprq_pkg::CMD_DEQ
			: r < 95 ? pprq_pkg::CMD_PRE : pprq_pkg::CMD_NOP;
		it.thread_id = ($urandom_range(99) < 70) ? 6'($urandom_range(15))
			: 6'($urandom_range(63));
		it.priority_req = ($urandom_range(99) < 75) ? 6'($urandom_range(7))
			: 6'($urandom_range(63));
		r = $urandom_range(99);
		it.pin = r < 40 ? 4'hF : r < 50 ? 4'($urandom_range(8, 15)) : 4'($urandom_range(7));
		it.cpu_id = 3'($urandom_range(7));
		it.max_priority = ($urandom_range(99) < 70) ? 6'd63 : 6'($urandom_range(63));
		return it;
	endfunction

	// Wait until every expected response has come back.
	task automatic drain();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, duplicates, pins, extremes, preempt cases.
		send_fields(pprq_pkg::CMD_DEQ, 0, 0, -1, 0, 63);
		send_fields(pprq_pkg::CMD_PRE, 9, 5, -1, 3, 0);
		send_fields(pprq_pkg::CMD_ENQ, 0, 0, -1, 0, 0);
		send_fields(pprq_pkg::CMD_ENQ, 0, 7, 3, 0, 0);
		send_fields(pprq_pkg::CMD_ENQ, 63, 63, 7, 7, 63);
		send_fields(pprq_pkg::CMD_ENQ, 42, 63, -8, 0, 0);
		send_fields(pprq_pkg::CMD_ENQ, 21, 2, 5, 0, 0);
		send_fields(pprq_pkg::CMD_DEQ, 0, 0, 0, 4, 1);
		send_fields(pprq_pkg::CMD_DEQ, 0, 0, 0, 5, 63);
		send_fields(pprq_pkg::CMD_DEQ, 0, 0, 0, 7, 63);
		send_fields(pprq_pkg::CMD_DEQ, 0, 0, 0, 7, 62);
		send_fields(pprq_pkg::CMD_PRE, 63, 63, 7, 7, 0);
		send_fields(pprq_pkg::CMD_ENQ, 30, 4, -1, 0, 0);
		send_fields(pprq_pkg::CMD_PRE, 30, 4, -1, 1, 0);
		send_fields(pprq_pkg::CMD_PRE, 12, 3, 6, 2, 0);
		send_fields(pprq_pkg::CMD_NOP, 63, 63, -1, 7, 63);
		send_fields(pprq_pkg::CMD_DEQ, 0, 0, 0, 0, 63);
		send_fields(pprq_pkg::CMD_DEQ, 0, 0, 0, 6, 63);
		send_fields(pprq_pkg::CMD_DEQ, 0, 0, 0, 7, 63);
		send_fields(pprq_pkg::CMD_DEQ, 0, 0, 0, 7, 63);
		req_ch.valid <= 1'b0;
		drain();

		// Random: four phases of sender idling and response stalls, a long response hold-off in the second.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = ph == 1 || ph == 3 ? (ph == 1 ? 84 : 33) : 0;
			stall_pct = ph == 2 ? 84 : ph == 3 ? 33 : 0;
			if (ph == 1) begin
				idle_pct = 0;
				hold_req <= 1'b1;
			end
			for (int n = 0; n < 385; n++) begin
				if (ph == 1 && n == 40) idle_pct = 84;
				send(random_request());
			end
			req_ch.valid <= 1'b0;
			drain();
		end

		repeat (300) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
